// File: rtl/core/lrgc_pkg.sv
`timescale 1ns / 1ps

package lrgc_pkg;

  localparam int OUT_RATE_DEFAULT = 48000;

  localparam int SAMPLE_W    = 16;
  localparam int RATE_W      = 17;
  localparam int GAIN_W      = 16;
  localparam int GAIN_FRAC   = 12;
  localparam int CFG_INDEX_W = 2;

  localparam int MAX_RESULTS = 12;
  localparam int CNT_W       = 4;

  localparam logic [RATE_W-1:0] SOURCE_RATE_RESET = RATE_W'(48000);
  localparam logic [GAIN_W-1:0] GAIN_RESET        = GAIN_W'(4096);

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SOURCE_RATE,
    CFG_MONO_INPUT,
    CFG_GAIN_Q12
  } cfg_reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD,
    S_MOD
  } seq_state_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_in;
    logic signed [SAMPLE_W-1:0] right_in;
    logic                       final_frame;
  } src_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left_out;
    logic signed [SAMPLE_W-1:0] right_out;
    logic                       run_end;
    logic                       clip_end;
  } dst_beat_t;

  typedef struct packed {
    logic run_end;
    logic clip_end;
  } frame_tag_t;

endpackage

// File: rtl/core/lrgc_seq.sv
`timescale 1ns / 1ps

module lrgc_seq #(
  parameter int OUT_RATE = lrgc_pkg::OUT_RATE_DEFAULT,
  localparam int PHW = $clog2(OUT_RATE)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [lrgc_pkg::RATE_W-1:0]           rate_cfg,
  input  logic                                  src_valid,
  output logic                                  src_stall,
  input  lrgc_pkg::src_beat_t                   src,
  output logic                                  iss_valid,
  output logic signed [lrgc_pkg::SAMPLE_W-1:0]  iss_al,
  output logic signed [lrgc_pkg::SAMPLE_W-1:0]  iss_bl,
  output logic signed [lrgc_pkg::SAMPLE_W-1:0]  iss_ar,
  output logic signed [lrgc_pkg::SAMPLE_W-1:0]  iss_br,
  output logic [PHW-1:0]                        iss_phase,
  output lrgc_pkg::frame_tag_t                  iss_tag
);
  import lrgc_pkg::*;

  localparam int PW = $clog2(OUT_RATE + 2**RATE_W);
  localparam int XW = $clog2(OUT_RATE + 1);
  localparam int SW = $clog2(XW);
  localparam logic [PW-1:0]    OUT_P = PW'(OUT_RATE);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_RESULTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RESULTS - 1);
  localparam logic [SW-1:0]    STEP_LAST = SW'(XW - 1);

  seq_state_t state, state_next;

  logic signed [SAMPLE_W-1:0] prev_l, prev_r, cur_l, cur_r;
  logic                       fin;
  logic                       have_prev;
  logic [RATE_W-1:0]          rate;
  logic [PW-1:0]              phase;
  logic [CNT_W-1:0]           cnt;
  logic [XW-1:0]              mod_x;
  logic [RATE_W-1:0]          mod_rem;
  logic [SW-1:0]              mod_step;

  logic              accept;
  logic              run_ends, at_cap, hold_go, mod_last, commit;
  logic [PW-1:0]     nph, nph_m, out_gap;
  logic              nph_ge, last;
  logic [RATE_W:0]   rem_sh;
  logic [RATE_W-1:0] rem_new;

  assign accept   = src_valid && !src_stall;
  assign run_ends = phase >= OUT_P;
  assign at_cap   = cnt == CNT_MAX;
  assign hold_go  = !run_ends && !at_cap;
  assign nph      = phase + PW'(rate);
  assign nph_ge   = nph >= OUT_P;
  assign nph_m    = nph - OUT_P;
  assign out_gap  = OUT_P - phase;
  assign mod_last = (state == S_MOD) && (mod_step == STEP_LAST);

  // one bit of the remainder of (OUT_RATE - phase) by rate per cycle
  assign rem_sh  = {mod_rem, mod_x[XW-1]};
  assign rem_new = (rem_sh >= {1'b0, rate}) ? RATE_W'(rem_sh - {1'b0, rate})
                                            : rem_sh[RATE_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (have_prev) begin
            state_next = S_RUN;
          end else if (src.final_frame) begin
            state_next = S_HOLD;
          end
        end
      end
      S_RUN: begin
        if (en) begin
          if (run_ends) begin
            state_next = fin ? S_HOLD : S_IDLE;
          end else if (at_cap) begin
            state_next = S_MOD;
          end
        end
      end
      S_HOLD: begin
        if (en && !hold_go) begin
          state_next = S_IDLE;
        end
      end
      S_MOD: begin
        if (mod_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    src_stall = 1'b1;
    iss_valid = 1'b0;
    commit    = 1'b0;
    last      = 1'b0;
    iss_al    = prev_l;
    iss_bl    = cur_l;
    iss_ar    = prev_r;
    iss_br    = cur_r;
    case (state)
      S_IDLE: begin
        src_stall = 1'b0;
      end
      S_RUN: begin
        iss_valid = en && !run_ends && !at_cap;
        commit    = en && run_ends && !fin;
        // last of the item unless held frames follow on a final beat
        last      = (cnt == CNT_LAST) || (nph_ge && !(fin && (nph_m < OUT_P)));
      end
      S_HOLD: begin
        iss_valid = en && hold_go;
        commit    = en && !hold_go;
        last      = (cnt == CNT_LAST) || nph_ge;
        iss_al    = cur_l;
        iss_ar    = cur_r;
      end
      S_MOD: begin
        commit = mod_last;
      end
      default: begin
        src_stall = 1'b1;
      end
    endcase
  end

  assign iss_phase       = phase[PHW-1:0];
  assign iss_tag.run_end = last;
  assign iss_tag.clip_end = last && fin;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      phase     <= '0;
      cnt       <= '0;
      prev_l    <= '0;
      prev_r    <= '0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_l <= src.left_in;
            cur_r <= src.right_in;
            fin   <= src.final_frame;
            rate  <= (rate_cfg == '0) ? RATE_W'(1) : rate_cfg;
            cnt   <= '0;
            if (!have_prev) begin
              phase <= '0;
              if (!src.final_frame) begin
                prev_l    <= src.left_in;
                prev_r    <= src.right_in;
                have_prev <= 1'b1;
              end
            end
          end
        end
        S_RUN: begin
          if (en) begin
            if (run_ends) begin
              phase <= phase - OUT_P;
            end else if (at_cap) begin
              mod_x    <= out_gap[XW-1:0];
              mod_rem  <= '0;
              mod_step <= '0;
            end else begin
              phase <= nph;
              cnt   <= cnt + CNT_W'(1);
            end
          end
        end
        S_HOLD: begin
          if (en && hold_go) begin
            phase <= nph;
            cnt   <= cnt + CNT_W'(1);
          end
        end
        S_MOD: begin
          mod_x    <= mod_x << 1;
          mod_rem  <= rem_new;
          mod_step <= mod_step + SW'(1);
          // a final beat restarts the clip at phase zero below
          if (mod_last && !fin) begin
            phase <= (rem_new == '0) ? '0 : PW'(rate - rem_new);
          end
        end
        default: begin
          cnt <= '0;
        end
      endcase
      if (commit) begin
        prev_l    <= cur_l;
        prev_r    <= cur_r;
        have_prev <= !fin;
        if (fin) begin
          phase <= '0;
        end
      end
    end
  end

endmodule

// File: rtl/core/lrgc_lane.sv
`timescale 1ns / 1ps

module lrgc_lane #(
  parameter int OUT_RATE = lrgc_pkg::OUT_RATE_DEFAULT,
  localparam int PHW = $clog2(OUT_RATE)
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic [lrgc_pkg::GAIN_W-1:0]           gain,
  input  logic                                  in_valid,
  input  logic signed [lrgc_pkg::SAMPLE_W-1:0]  in_a,
  input  logic signed [lrgc_pkg::SAMPLE_W-1:0]  in_b,
  input  logic [PHW-1:0]                        in_phase,
  input  lrgc_pkg::frame_tag_t                  in_tag,
  output logic                                  out_valid,
  output logic signed [lrgc_pkg::SAMPLE_W-1:0]  out_value,
  output lrgc_pkg::frame_tag_t                  out_tag
);
  import lrgc_pkg::*;

  localparam int    AW       = PHW + 18;
  localparam int    PW2      = AW + GAIN_W + 1;
  localparam longint SAT_L   = 64'd32768 * OUT_RATE;
  localparam int    MW       = $clog2(SAT_L);
  localparam int    SH       = MW + 1;
  localparam longint RECIP_L = (64'd1 << SH) / OUT_RATE;
  localparam int    RW       = $clog2(RECIP_L + 1);
  localparam int    QW       = SAMPLE_W;

  localparam logic signed [AW-1:0] OUT_S   = AW'(OUT_RATE);
  localparam logic [PW2-1:0]       SAT_LIM = PW2'(SAT_L);
  localparam logic [MW+RW-1:0]     RECIP   = (MW+RW)'(RECIP_L);
  localparam logic [MW-1:0]        OUT_M   = MW'(OUT_RATE);

  logic [5:0] vld;
  frame_tag_t tag1, tag2, tag3, tag4, tag5;

  // stage 1: a*(OUT - ph) + b*ph written as a*OUT + (b - a)*ph
  logic signed [AW-1:0] a_x, d_x, ph_x, acc;
  assign a_x  = AW'(in_a);
  assign d_x  = AW'(in_b) - AW'(in_a);
  assign ph_x = AW'(in_phase);

  // stage 2: gain
  logic signed [GAIN_W:0]  gain_s;
  logic signed [PW2-1:0]   prod_g;
  assign gain_s = {1'b0, gain};

  // stage 3: magnitude, drop the q12 fraction, saturation test
  logic [PW2-1:0] mag, mag_sh;
  logic           neg3, sat3;
  logic [MW-1:0]  m3;
  assign mag    = prod_g[PW2-1] ? PW2'(-prod_g) : PW2'(prod_g);
  assign mag_sh = mag >> GAIN_FRAC;

  // stage 4: reciprocal multiply for the divide by OUT_RATE
  logic [MW+RW-1:0] prod_r;
  logic             neg4, sat4;
  logic [MW-1:0]    m4;

  // stage 5: estimate, never more than one short
  logic [QW-1:0] qe5;
  logic [MW-1:0] qo5, m5;
  logic          neg5, sat5;
  logic [QW-1:0] qe_w;
  assign qe_w = prod_r[SH +: QW];

  // stage 6: correction, sign and clamp
  logic [MW-1:0] rem6;
  logic [QW-1:0] q6;
  assign rem6 = m5 - qo5;
  assign q6   = qe5 + QW'(rem6 >= OUT_M);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc  <= a_x * OUT_S + d_x * ph_x;
      tag1 <= in_tag;

      prod_g <= PW2'(acc) * PW2'(gain_s);
      tag2   <= tag1;

      neg3 <= prod_g[PW2-1];
      sat3 <= mag_sh >= SAT_LIM;
      m3   <= mag_sh[MW-1:0];
      tag3 <= tag2;

      prod_r <= (MW+RW)'(m3) * RECIP;
      neg4   <= neg3;
      sat4   <= sat3;
      m4     <= m3;
      tag4   <= tag3;

      qe5  <= qe_w;
      qo5  <= MW'(qe_w) * OUT_M;
      m5   <= m4;
      neg5 <= neg4;
      sat5 <= sat4;
      tag5 <= tag4;

      if (sat5) begin
        out_value <= neg5 ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
        out_value <= neg5 ? -$signed(q6) : $signed(q6);
      end
      out_tag <= tag5;
    end
  end

  assign out_valid = vld[5];

endmodule

// File: rtl/core/lrgc_merge.sv
`timescale 1ns / 1ps

module lrgc_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  en,
  input  logic                                  mono,
  input  logic                                  l_valid,
  input  logic signed [lrgc_pkg::SAMPLE_W-1:0]  l_value,
  input  lrgc_pkg::frame_tag_t                  l_tag,
  input  logic signed [lrgc_pkg::SAMPLE_W-1:0]  r_value,
  output logic                                  dst_valid,
  output lrgc_pkg::dst_beat_t                   dst
);
  import lrgc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else if (en) begin
      dst_valid <= l_valid;
    end
  end

  // mono copies the left lane to both channels
  always_ff @(posedge clk) begin
    if (en && l_valid) begin
      dst.left_out  <= l_value;
      dst.right_out <= mono ? l_value : r_value;
      dst.run_end   <= l_tag.run_end;
      dst.clip_end  <= l_tag.clip_end;
    end
  end

endmodule

// File: rtl/core/linear_resampler_gain_clamp.sv
`timescale 1ns / 1ps

// channel  dir  handshake              beat
// src      in   src_valid / src_stall  left_in, right_in, final_frame
// dst      out  dst_valid / dst_stall  left_out, right_out, run_end, clip_end
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a source beat holds the sequencer until its frames are issued, and longer with
// held frames after a final beat; one frame enters both lanes per cycle unless the output stalls
// when more than 12 frames fall on one beat the frames past the twelfth are dropped and
// the phase remainder unit steps the phase over them before the next beat is taken
// lanes are six stages plus the output register, which a frame passes through after issue
// rst is synchronous and returns the registers to their defaults and the clip to its start
// dst_stall with dst_valid high freezes the lanes and the sequencer; a source beat is still taken while idle
module linear_resampler_gain_clamp #(
  parameter int OUT_RATE = lrgc_pkg::OUT_RATE_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 src_valid,
  output logic                                 src_stall,
  input  lrgc_pkg::src_beat_t                  src,
  output logic                                 dst_valid,
  input  logic                                 dst_stall,
  output lrgc_pkg::dst_beat_t                  dst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [lrgc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [lrgc_pkg::RATE_W-1:0]          cfg_data
);
  import lrgc_pkg::*;

  localparam int PHW = $clog2(OUT_RATE);

  logic [RATE_W-1:0] source_rate;
  logic              mono_input;
  logic [GAIN_W-1:0] gain_q12;

  logic en;

  logic                       iss_valid;
  logic signed [SAMPLE_W-1:0] iss_al, iss_bl, iss_ar, iss_br;
  logic [PHW-1:0]             iss_phase;
  frame_tag_t                 iss_tag;

  logic                       l_valid, r_valid;
  logic signed [SAMPLE_W-1:0] l_value, r_value;
  frame_tag_t                 l_tag, r_tag;

  assign cfg_ready = 1'b1;
  assign en        = !(dst_valid && dst_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      source_rate <= SOURCE_RATE_RESET;
      mono_input  <= 1'b0;
      gain_q12    <= GAIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SOURCE_RATE: source_rate <= cfg_data;
        CFG_MONO_INPUT:  mono_input  <= cfg_data[0];
        CFG_GAIN_Q12:    gain_q12    <= cfg_data[GAIN_W-1:0];
        default:         mono_input  <= mono_input;
      endcase
    end
  end

  lrgc_seq #(.OUT_RATE(OUT_RATE)) u_seq (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .rate_cfg  (source_rate),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .iss_valid (iss_valid),
    .iss_al    (iss_al),
    .iss_bl    (iss_bl),
    .iss_ar    (iss_ar),
    .iss_br    (iss_br),
    .iss_phase (iss_phase),
    .iss_tag   (iss_tag)
  );

  lrgc_lane #(.OUT_RATE(OUT_RATE)) u_lane_l (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .gain      (gain_q12),
    .in_valid  (iss_valid),
    .in_a      (iss_al),
    .in_b      (iss_bl),
    .in_phase  (iss_phase),
    .in_tag    (iss_tag),
    .out_valid (l_valid),
    .out_value (l_value),
    .out_tag   (l_tag)
  );

  lrgc_lane #(.OUT_RATE(OUT_RATE)) u_lane_r (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .gain      (gain_q12),
    .in_valid  (iss_valid),
    .in_a      (iss_ar),
    .in_b      (iss_br),
    .in_phase  (iss_phase),
    .in_tag    (iss_tag),
    .out_valid (r_valid),
    .out_value (r_value),
    .out_tag   (r_tag)
  );

  lrgc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .mono      (mono_input),
    .l_valid   (l_valid),
    .l_value   (l_value),
    .l_tag     (l_tag),
    .r_value   (r_value),
    .dst_valid (dst_valid),
    .dst       (dst)
  );

`ifndef SYNTHESIS
  a_lanes_lockstep: assert property (@(posedge clk) disable iff (rst)
    l_valid |-> (r_valid && (r_tag == l_tag)))
    else $error("lanes out of step");

  a_no_issue_when_stalled: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst_stall) |-> !iss_valid)
    else $error("frame issued while output stalled");

  a_mono_copies: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && mono_input) |-> (dst.left_out == dst.right_out))
    else $error("mono beat with differing channels");

  a_clip_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    (dst_valid && dst.clip_end) |-> dst.run_end)
    else $error("clip end without run end");
`endif

endmodule

// File: sim/tb_linear_resampler_gain_clamp.sv
`timescale 1ns / 1ps

module tb_linear_resampler_gain_clamp;
  import lrgc_pkg::*;

  localparam longint OUT_HZ        = OUT_RATE_DEFAULT;
  localparam int     SETTLE_CYCLES = 160;

  logic        clk = 1'b0;
  logic        rst;
  logic        src_valid;
  logic        src_stall;
  src_beat_t   src;
  logic        dst_valid;
  logic        dst_stall;
  dst_beat_t   dst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [RATE_W-1:0]      cfg_data;

  // register shadow and resampler state as the block should hold them
  logic [RATE_W-1:0] cur_rate;
  logic              cur_mono;
  logic [GAIN_W-1:0] cur_gain;
  int                held_left;
  int                held_right;
  longint            phase_acc;
  bit                clip_open;

  dst_beat_t expected_frames[$];
  int        mismatch_count;
  int        src_idle_pct;
  int        dst_stall_pct;

  linear_resampler_gain_clamp u_top (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src       (src),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dst       (dst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    dst_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // exact interpolation, gain, truncation toward zero, then saturation
  function automatic logic signed [SAMPLE_W-1:0] scale_lerp(int a, int b, longint ph);
    longint acc;
    longint q;
    acc = longint'(a) * OUT_HZ + longint'(b - a) * ph;
    q = (acc * longint'(cur_gain)) / (OUT_HZ * 4096);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[SAMPLE_W-1:0];
  endfunction

  function automatic dst_beat_t make_frame(int al, int bl, int ar, int br, longint ph);
    dst_beat_t f;
    f.left_out  = scale_lerp(al, bl, ph);
    f.right_out = cur_mono ? f.left_out : scale_lerp(ar, br, ph);
    f.run_end   = 1'b0;
    f.clip_end  = 1'b0;
    return f;
  endfunction

  function automatic void predict_frames(src_beat_t b);
    dst_beat_t run_frames[MAX_RESULTS];
    longint    rate;
    longint    ph;
    int        n_out;
    int        l;
    int        r;
    rate  = (cur_rate == 0) ? 1 : longint'(cur_rate);
    l     = b.left_in;
    r     = b.right_in;
    ph    = phase_acc;
    n_out = 0;
    if (clip_open) begin
      while (ph < OUT_HZ && n_out < MAX_RESULTS) begin
        run_frames[n_out] = make_frame(held_left, l, held_right, r, ph);
        n_out++;
        ph += rate;
      end
      // frames past the twelfth are dropped but the phase still steps over them
      if (ph < OUT_HZ) ph += ((OUT_HZ - ph + rate - 1) / rate) * rate;
      ph -= OUT_HZ;
    end else begin
      ph = 0;
    end
    held_left  = l;
    held_right = r;
    clip_open  = 1'b1;
    phase_acc  = ph;
    if (b.final_frame) begin
      while (ph < OUT_HZ && n_out < MAX_RESULTS) begin
        run_frames[n_out] = make_frame(l, l, r, r, ph);
        n_out++;
        ph += rate;
      end
      held_left  = 0;
      held_right = 0;
      phase_acc  = 0;
      clip_open  = 1'b0;
    end
    if (n_out > 0) begin
      run_frames[n_out-1].run_end  = 1'b1;
      run_frames[n_out-1].clip_end = b.final_frame;
    end
    for (int i = 0; i < n_out; i++) expected_frames.push_back(run_frames[i]);
  endfunction

  always @(posedge clk) begin
    dst_beat_t want;
    if (!rst && dst_valid && !dst_stall) begin
      if (expected_frames.size() == 0) begin
        $error("unexpected output beat: left_out %0d right_out %0d", dst.left_out,
               dst.right_out);
        mismatch_count++;
      end else begin
        want = expected_frames.pop_front();
        if (dst.left_out !== want.left_out) begin
          $error("left_out: expected %0d, got %0d", want.left_out, dst.left_out);
          mismatch_count++;
        end
        if (dst.right_out !== want.right_out) begin
          $error("right_out: expected %0d, got %0d", want.right_out, dst.right_out);
          mismatch_count++;
        end
        if (dst.run_end !== want.run_end) begin
          $error("run_end: expected %0d, got %0d", want.run_end, dst.run_end);
          mismatch_count++;
        end
        if (dst.clip_end !== want.clip_end) begin
          $error("clip_end: expected %0d, got %0d", want.clip_end, dst.clip_end);
          mismatch_count++;
        end
      end
    end
  end

  // valid stays high after the beat so back-to-back frames need no toggle
  task automatic send_frame(src_beat_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      src_valid <= 1'b0;
      @(posedge clk);
    end
    src_valid <= 1'b1;
    src       <= b;
    @(posedge clk);
    while (src_stall) @(posedge clk);
    predict_frames(b);
  endtask

  task automatic send_sample(int l, int r, bit last);
    src_beat_t b;
    b.left_in     = l[SAMPLE_W-1:0];
    b.right_in    = r[SAMPLE_W-1:0];
    b.final_frame = last;
    send_frame(b);
  endtask

  task automatic hold_until_drained();
    src_valid <= 1'b0;
    @(posedge clk);
    while (expected_frames.size() != 0) @(posedge clk);
  endtask

  // a beat with no output may still be in flight once the queue is empty
  task automatic settle();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [RATE_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_SOURCE_RATE: cur_rate = val;
      CFG_MONO_INPUT:  cur_mono = val[0];
      default:         cur_gain = val[GAIN_W-1:0];
    endcase
  endtask

  task automatic set_config(logic [RATE_W-1:0] rate, logic mono, logic [GAIN_W-1:0] gain);
    settle();
    write_reg(CFG_SOURCE_RATE, rate);
    write_reg(CFG_MONO_INPUT, RATE_W'(mono));
    write_reg(CFG_GAIN_Q12, RATE_W'(gain));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [RATE_W-1:0] random_rate();
    case ($urandom_range(15))
      0:       return RATE_W'(8000);
      1:       return RATE_W'(96000);
      2:       return RATE_W'(48000);
      3:       return RATE_W'(44100);
      4:       return RATE_W'(11025);
      5:       return ($urandom_range(3) == 0) ? RATE_W'(0) : RATE_W'(131071);
      default: return RATE_W'($urandom_range(8000, 96000));
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(9))
      0:       return GAIN_W'(0);
      1:       return GAIN_W'(1);
      2:       return GAIN_W'(32768);
      3:       return GAIN_RESET;
      default: return GAIN_W'($urandom_range(1, 32768));
    endcase
  endfunction

  function automatic int pick_sample(int style);
    logic [SAMPLE_W-1:0] v;
    case (style)
      0:       v = $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
      1:       v = SAMPLE_W'($urandom_range(512)) - SAMPLE_W'(256);
      default: v = SAMPLE_W'($urandom);
    endcase
    return int'($signed(v));
  endfunction

  task automatic send_clip(int frames, int style, bit closed);
    for (int i = 0; i < frames; i++) begin
      send_sample(pick_sample(style), pick_sample(style), closed && (i == frames - 1));
    end
  endtask

  task automatic test_reset_defaults();
    send_sample(1234, -1234, 1'b1);
    send_sample(32767, -32768, 1'b0);
    send_sample(-32768, 32767, 1'b0);
    send_sample(0, -1, 1'b0);
    send_sample(1, 0, 1'b0);
    send_sample(32767, 32767, 1'b1);
  endtask

  task automatic test_rate_extremes();
    // above 96 kHz a final beat can land with no frame left to emit
    set_config(RATE_W'(131071), 1'b0, GAIN_RESET);
    send_sample(100, -100, 1'b0);
    send_sample(-32768, 32767, 1'b0);
    send_sample(32767, -32768, 1'b0);
    send_sample(-5, 5, 1'b0);
    send_sample(7, -7, 1'b1);
    // zero rate acts as one, so every beat after the first overflows the twelve-frame cap
    set_config(RATE_W'(0), 1'b0, GAIN_W'(32768));
    send_sample(32767, -32768, 1'b0);
    send_sample(-32768, 32767, 1'b0);
    send_sample(16, -16, 1'b1);
  endtask

  task automatic test_gain_and_mono();
    set_config(RATE_W'(48000), 1'b0, GAIN_W'(0));
    send_sample(32767, -32768, 1'b0);
    send_sample(-32768, 32767, 1'b1);
    set_config(RATE_W'(22050), 1'b1, GAIN_W'(32768));
    send_sample(32767, 5, 1'b0);
    send_sample(-32768, -9, 1'b0);
    send_sample(300, 32767, 1'b0);
    send_sample(-300, -32768, 1'b1);
    set_config(RATE_W'(8000), 1'b1, GAIN_W'(1));
    send_sample(32767, 0, 1'b0);
    send_sample(-32768, 1, 1'b0);
    send_sample(12345, -1, 1'b1);
  endtask

  // source goes quiet mid-clip until the output side has caught up
  task automatic test_drained_restart();
    set_config(RATE_W'(44100), 1'b0, GAIN_RESET);
    send_clip(5, 2, 1'b0);
    hold_until_drained();
    send_clip(5, 2, 1'b1);
  endtask

  task automatic test_random_traffic(int sp, int dp, int n_items);
    int sent;
    int len;
    src_idle_pct  = sp;
    dst_stall_pct = dp;
    sent = 0;
    while (sent < n_items) begin
      // an open clip carried over here sees its registers change mid-clip
      if (sent == 0 || $urandom_range(3) == 0) begin
        set_config(random_rate(), 1'($urandom_range(1)), random_gain());
      end
      len = ($urandom_range(4) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 24);
      send_clip(len, $urandom_range(3), $urandom_range(4) != 0);
      sent += len;
    end
  endtask

  initial begin
    rst            = 1'b1;
    src_valid      = 1'b0;
    src            = '0;
    cfg_valid      = 1'b0;
    cfg_index      = '0;
    cfg_data       = '0;
    cur_rate       = SOURCE_RATE_RESET;
    cur_mono       = 1'b0;
    cur_gain       = GAIN_RESET;
    held_left      = 0;
    held_right     = 0;
    phase_acc      = 0;
    clip_open      = 1'b0;
    mismatch_count = 0;
    src_idle_pct   = 16;
    dst_stall_pct  = 62;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_rate_extremes();
    test_gain_and_mono();
    test_drained_restart();
    test_random_traffic(16, 62, 100);
    test_random_traffic(62, 16, 100);
    test_random_traffic(0, 0, 100);

    settle();
    if (mismatch_count == 0) begin
      $display("tb_linear_resampler_gain_clamp: done, clean");
    end else begin
      $display("tb_linear_resampler_gain_clamp: done, errors");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("tb_linear_resampler_gain_clamp: done, errors");
    $finish;
  end

endmodule
